@@ hw/rtl/atis_pkg.sv @@
package atis_pkg;

    localparam int ATIS_DEPTH = 16;
    localparam int VALUE_W    = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [2:0] MODE_APPEND   = 3'd0;
    localparam logic [2:0] MODE_POP      = 3'd1;
    localparam logic [2:0] MODE_REMOVE   = 3'd2;
    localparam logic [2:0] MODE_CONTAINS = 3'd3;
    localparam logic [2:0] MODE_INSERT   = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NOMATCH = 2'd3
    } atis_status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_APPEND,
        OP_POP,
        OP_REMOVE,
        OP_CONTAINS,
        OP_INSERT
    } atis_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } atis_state_t;

    typedef struct packed {
        atis_op_t             kind;
        logic [VALUE_W-1:0]   value;
    } atis_cmd_t;

    // token walking down the row of cells
    typedef struct packed {
        logic                 active;
        logic                 seen;
        logic [VALUE_W-1:0]   data;
    } atis_link_t;

endpackage

@@ hw/rtl/array_table_insert_remove_search_unit.sv @@
// table of signed 32-bit entries kept in a row of DEPTH cells, with an entry count
// input words on s_tvalid/s_tready/s_tdata carry a mode and a value:
//   append, pop last, remove first match, contains, ordered insert
// every input word yields exactly one output word on m_tvalid/m_tready/m_tdata
// carrying status, found flag, popped value and the entry count after the operation
// an accepted word launches a token that walks the row one cell per clock; each
// cell compares, shifts or swaps its entry as the token passes
// a new word is taken only after the previous result has been loaded into the output register
// s_tready is high only while no operation is in flight; a finished word waits in
// the output register while the next input word may already be taken
// when the receiver stalls the output word holds and the next result waits
// append or insert on a full table is rejected with status full
// reset clears every cell to zero and the count to zero; no clearing pass needed
module array_table_insert_remove_search_unit
    import atis_pkg::*;
#(
    parameter int DEPTH = ATIS_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // mode[2:0], value[34:3], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // status[1:0], found[2], read_value[34:3],
                                            // count[39:35]
);

    localparam int CW = $clog2(DEPTH + 1);

    atis_state_t            state_reg;
    atis_state_t            state_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    atis_cmd_t              cmd_reg;
    atis_cmd_t              cmd_next;
    logic [CW-1:0]          target_reg;
    logic [CW-1:0]          target_next;
    atis_status_t           pre_status_reg;
    atis_status_t           pre_status_next;
    atis_link_t             head_reg;
    atis_link_t             tail_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    atis_link_t             link [0:DEPTH];
    logic [VALUE_W-1:0]     entry_q [0:DEPTH-1];

    logic [2:0]             in_mode;
    logic [VALUE_W-1:0]     in_value;
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   capture_tail;
    logic                   load_out;
    atis_status_t           res_status;
    logic                   res_found;
    logic [VALUE_W-1:0]     res_read;

    assign in_mode  = s_tdata[2:0];
    assign in_value = s_tdata[34:3];
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    // mode decode at accept
    always_comb
    begin
        cmd_next        = cmd_reg;
        target_next     = target_reg;
        pre_status_next = pre_status_reg;
        if (accept)
        begin
            cmd_next.value  = in_value;
            cmd_next.kind   = OP_NOP;
            target_next     = count_reg;
            pre_status_next = STAT_OK;
            unique case (in_mode)
                MODE_APPEND:
                begin
                    if (full)
                    begin
                        pre_status_next = STAT_FULL;
                    end
                    else
                    begin
                        cmd_next.kind = OP_APPEND;
                    end
                end
                MODE_POP:
                begin
                    cmd_next.kind = OP_POP;
                    if (empty)
                    begin
                        pre_status_next = STAT_EMPTY;
                        target_next     = '0;
                    end
                    else
                    begin
                        target_next = count_reg - CW'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    cmd_next.kind = OP_REMOVE;
                end
                MODE_CONTAINS:
                begin
                    cmd_next.kind = OP_CONTAINS;
                end
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        pre_status_next = STAT_FULL;
                    end
                    else
                    begin
                        cmd_next.kind = OP_INSERT;
                    end
                end
                default:
                begin
                    cmd_next.kind = OP_NOP;
                end
            endcase
        end
    end

    // row of cells
    assign link[0] = head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] upper;
            if (gi + 1 < DEPTH)
            begin : g_mid
                assign upper = entry_q[gi + 1];
            end
            else
            begin : g_top
                assign upper = '0;
            end
            atis_cell #(
                .DEPTH (DEPTH),
                .CW    (CW),
                .IDX   (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd_reg),
                .count      (count_reg),
                .target     (target_reg),
                .link_in    (link[gi]),
                .next_entry (upper),
                .link_out   (link[gi + 1]),
                .entry      (entry_q[gi])
            );
        end
    endgenerate

    // result from the token that left the last cell
    always_comb
    begin
        res_status = pre_status_reg;
        res_found  = 1'b0;
        res_read   = '0;
        count_next = count_reg;
        case (cmd_reg.kind)
            OP_APPEND, OP_INSERT:
            begin
                count_next = count_reg + CW'(1);
            end
            OP_POP:
            begin
                res_read = tail_reg.data;
                if (!empty)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (tail_reg.seen)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    res_status = STAT_NOMATCH;
                end
            end
            OP_CONTAINS:
            begin
                res_found = tail_reg.seen;
            end
            default:
            begin
            end
        endcase
        out_data_next = {5'(count_next), res_read, res_found, res_status};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (link[DEPTH].active)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready     = 1'b0;
        capture_tail = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_RUN:
            begin
                capture_tail = link[DEPTH].active;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '{kind: OP_NOP, value: '0};
            pre_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            pre_status_reg <= pre_status_next;
            head_reg       <= '{active: accept, seen: 1'b0, data: '0};
            out_valid_reg  <= out_valid_next;
            if (load_out)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        if (capture_tail)
        begin
            tail_reg <= link[DEPTH];
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        link[DEPTH].active |-> state_reg == ST_RUN)
        else $error("token left the row outside an operation");

    a_count_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(load_out))
        else $error("count changed without a result word");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside done state");
`endif

endmodule

@@ hw/rtl/atis_cell.sv @@
module atis_cell
    import atis_pkg::*;
#(
    parameter int DEPTH = ATIS_DEPTH,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int IDX   = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  atis_cmd_t          cmd,
    input  logic [CW-1:0]      count,
    input  logic [CW-1:0]      target,
    input  atis_link_t         link_in,
    input  logic [VALUE_W-1:0] next_entry,
    output atis_link_t         link_out,
    output logic [VALUE_W-1:0] entry
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    atis_link_t         link_reg;
    atis_link_t         link_next;
    logic               occ;
    logic               at_end;
    logic               eq;
    logic               gt;
    logic               hit;
    logic               place;

    always_comb
    begin
        occ        = (IDX_C < count);
        at_end     = (IDX_C == count);
        eq         = occ && (entry_reg == cmd.value);
        gt         = occ && ($signed(entry_reg) > $signed(cmd.value));
        hit        = 1'b0;
        place      = 1'b0;
        link_next  = link_in;
        entry_next = entry_reg;
        if (link_in.active)
        begin
            case (cmd.kind)
                OP_APPEND:
                begin
                    if (IDX_C == target)
                    begin
                        entry_next = cmd.value;
                    end
                end
                OP_POP:
                begin
                    if (IDX_C == target)
                    begin
                        link_next.data = entry_reg;
                    end
                end
                OP_REMOVE:
                begin
                    hit = eq && !link_in.seen;
                    // last occupied cell keeps its stale value
                    if ((hit || link_in.seen) && occ && (NEXT_C < count))
                    begin
                        entry_next = next_entry;
                    end
                    link_next.seen = link_in.seen || hit;
                end
                OP_CONTAINS:
                begin
                    link_next.seen = link_in.seen || eq;
                end
                OP_INSERT:
                begin
                    place = !link_in.seen && (at_end || gt);
                    if (place)
                    begin
                        entry_next     = cmd.value;
                        link_next.data = entry_reg;
                        link_next.seen = 1'b1;
                    end
                    else if (link_in.seen && (occ || at_end))
                    begin
                        // ripple the displaced entry one cell up
                        entry_next     = link_in.data;
                        link_next.data = entry_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            link_reg  <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            link_reg  <= link_next;
        end
    end

    assign link_out = link_reg;
    assign entry    = entry_reg;

endmodule
